FILE: sv/rsch_pkg.sv
// Shared types, constants and helpers for the ray-sphere closest-hit block.
package rsch_pkg;

  localparam int SPHERE_SLOTS = 64;
  localparam int SLOT_W = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;
  localparam int IDX_W = $clog2(SPHERE_SLOTS + 1);

  typedef logic [SLOT_W-1:0] slot_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_DIV = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [6:0] SQRT_STEPS = 7'd64;

  typedef struct packed {
    logic kind;
    logic [5:0] entry_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] sphere_radius;
    logic signed [31:0] t_min;
    logic signed [31:0] t_max;
  } query_t;

  typedef struct packed {
    logic hit;
    logic signed [31:0] hit_t;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic front_face;
  } result_t;

  typedef struct packed {
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
    logic [30:0] r;
  } sphere_t;

  typedef struct packed {
    logic start;
    logic [1:0] op;
    logic [127:0] a;
    logic [127:0] b;
    logic [6:0] nbits;
  } alu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [127:0] result;
  } alu_rsp_t;

  // Clamp a wide two's complement value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [127:0] v);
    logic signed [31:0] r;
    if (v > 128'sd2147483647) r = 32'sh7fffffff;
    else if (v < -128'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

FILE: sv/rsch_alu.sv
// Shared iterative unit: shift-add multiply, restoring floor divide, integer square root.
module rsch_alu (
  input  logic clk,
  input  logic rst,
  input  rsch_pkg::alu_req_t req,
  output rsch_pkg::alu_rsp_t rsp
);

  logic busy, fin, done, neg;
  logic [1:0] op;
  logic [127:0] acc, x, y, z;
  logic [6:0] cnt;
  logic [127:0] abs_a, abs_b, rtmp, sub_b, diff;
  logic ge, bump;

  always_comb begin
    abs_a = req.a[127] ? (~req.a + 128'd1) : req.a;
    abs_b = req.b[127] ? (~req.b + 128'd1) : req.b;
    if (op == rsch_pkg::OP_SQRT) begin
      rtmp = {x[125:0], y[127:126]};
      sub_b = {acc[125:0], 2'b01};
    end else begin
      rtmp = {x[126:0], y[127]};
      sub_b = z;
    end
    ge = rtmp >= sub_b;
    diff = rtmp - sub_b;
    // A negative dividend with a remainder rounds one further down.
    bump = (op == rsch_pkg::OP_DIV) && (x != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (fin) begin
        fin <= 1'b0;
        busy <= 1'b0;
        done <= 1'b1;
        if (neg) acc <= bump ? ~acc : (~acc + 128'd1);
      end else if (busy) begin
        unique case (op)
          rsch_pkg::OP_MUL: begin
            if (y == '0) begin
              fin <= 1'b1;
            end else begin
              if (y[0]) acc <= acc + x;
              x <= x << 1;
              y <= y >> 1;
            end
          end
          rsch_pkg::OP_DIV, rsch_pkg::OP_SQRT: begin
            if (cnt == '0) begin
              fin <= 1'b1;
            end else begin
              x <= ge ? diff : rtmp;
              acc <= {acc[126:0], ge};
              y <= (op == rsch_pkg::OP_DIV) ? (y << 1) : (y << 2);
              cnt <= cnt - 7'd1;
            end
          end
          default: fin <= 1'b1;
        endcase
      end else if (req.start) begin
        busy <= 1'b1;
        op <= req.op;
        acc <= '0;
        z <= req.b;
        unique case (req.op)
          rsch_pkg::OP_MUL: begin
            x <= abs_a;
            y <= abs_b;
            neg <= req.a[127] ^ req.b[127];
            cnt <= req.nbits;
          end
          rsch_pkg::OP_DIV: begin
            x <= '0;
            y <= abs_a << (8'd128 - {1'b0, req.nbits});
            neg <= req.a[127];
            cnt <= req.nbits;
          end
          rsch_pkg::OP_SQRT: begin
            x <= '0;
            y <= req.a;
            neg <= 1'b0;
            cnt <= rsch_pkg::SQRT_STEPS;
          end
          default: begin
            x <= '0;
            y <= req.a;
            neg <= 1'b0;
            cnt <= req.nbits;
          end
        endcase
      end
    end
  end

  assign rsp.busy = busy;
  assign rsp.done = done;
  assign rsp.result = acc;

endmodule

FILE: sv/rsch_table.sv
// Sphere table memory: one write port, one registered read port.
module rsch_table (
  input  logic clk,
  input  logic we,
  input  rsch_pkg::slot_t waddr,
  input  rsch_pkg::sphere_t wdata,
  input  rsch_pkg::slot_t raddr,
  output rsch_pkg::sphere_t rdata
);

  rsch_pkg::sphere_t mem [rsch_pkg::SPHERE_SLOTS];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ray_sphere_closest_hit_top.sv
// Top level: sphere table, query sequencer and result register for closest-hit ray casts.
// A load request writes the table directly. A query forms the squared direction length,
// then tests each listed sphere in turn and shades a hit; each of these steps runs on the
// single shared multiply/divide/sqrt unit, which works one bit per cycle. A query is
// accepted only when the sequencer is idle.
// Reset (synchronous, active high) clears sphere_count and all control; the table is kept.
module ray_sphere_closest_hit_top (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [6:0] cfg_data,
  input  logic query_valid,
  output logic query_ready,
  input  rsch_pkg::query_t query,
  output logic result_valid,
  input  logic result_ready,
  output rsch_pkg::result_t result
);

  // Sequencer steps. Every step except idle, next, read and out runs one unit operation.
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_A     = 5'd1;
  localparam logic [4:0] ST_NEXT  = 5'd2;
  localparam logic [4:0] ST_READ  = 5'd3;
  localparam logic [4:0] ST_CRP   = 5'd4;
  localparam logic [4:0] ST_CRQ   = 5'd5;
  localparam logic [4:0] ST_CRS   = 5'd6;
  localparam logic [4:0] ST_R2    = 5'd7;
  localparam logic [4:0] ST_AR2   = 5'd8;
  localparam logic [4:0] ST_SQRT  = 5'd9;
  localparam logic [4:0] ST_H     = 5'd10;
  localparam logic [4:0] ST_ROOT1 = 5'd11;
  localparam logic [4:0] ST_ROOT2 = 5'd12;
  localparam logic [4:0] ST_PT    = 5'd13;
  localparam logic [4:0] ST_NRM   = 5'd14;
  localparam logic [4:0] ST_DOT   = 5'd15;
  localparam logic [4:0] ST_OUT   = 5'd16;

  // Dividend widths: the root numerator stays below 2^83, the normal numerator below 2^49.
  localparam logic [6:0] DIV_T_BITS = 7'd84;
  localparam logic [6:0] DIV_N_BITS = 7'd50;

  function automatic logic [127:0] ext(input logic signed [66:0] v);
    return {{61{v[66]}}, v};
  endfunction

  logic [4:0] st;
  logic issued;
  logic [1:0] k;
  logic [6:0] sphere_count;
  rsch_pkg::idx_t idx, nlim;
  logic signed [31:0] ox, oy, oz, dx, dy, dz, tmin, closest;
  logic [63:0] a_reg;
  logic signed [31:0] cx, cy, cz;
  logic [30:0] rr;
  logic signed [32:0] ocx, ocy, ocz;
  logic signed [65:0] tmp;
  logic [63:0] m;
  logic [127:0] sum;
  logic [61:0] r2;
  logic [126:0] disc;
  logic [63:0] s;
  logic signed [66:0] h;
  logic best_valid;
  logic signed [31:0] best_t, bcx, bcy, bcz;
  logic [30:0] br;
  logic signed [31:0] px, py, pz, nx, ny, nz;
  logic signed [65:0] dot;

  rsch_pkg::alu_req_t alu_req;
  rsch_pkg::alu_rsp_t alu_rsp;
  rsch_pkg::sphere_t rd, wd;
  logic tbl_we;

  logic alu_state;
  logic signed [31:0] dsel, osel, psel, bcsel, nsel, crp_d, crq_d;
  logic signed [32:0] ocsel, crp_oc, crq_oc, pdiff;
  logic signed [127:0] res_s;
  logic signed [65:0] cr;
  logic [65:0] crmag;
  logic signed [31:0] tsat, ptv;
  logic t_in, accept_now;
  rsch_pkg::result_t out_next;

  assign query_ready = (st == ST_IDLE);

  // A load request writes the table directly; slots past the table are dropped.
  assign tbl_we = query_valid && query_ready && !query.kind &&
                  (32'(query.entry_index) < rsch_pkg::SPHERE_SLOTS);
  assign wd.cx = query.pos_x;
  assign wd.cy = query.pos_y;
  assign wd.cz = query.pos_z;
  assign wd.r = query.sphere_radius[31] ? 31'd0 : query.sphere_radius[30:0];

  rsch_table u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (rsch_pkg::slot_t'(query.entry_index)),
    .wdata (wd),
    .raddr (rsch_pkg::slot_t'(idx)),
    .rdata (rd)
  );

  rsch_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Per-axis selection for the steps that walk x, y, z with k.
  always_comb begin
    unique case (k)
      2'd0: begin
        dsel = dx; osel = ox; ocsel = ocx; psel = px; bcsel = bcx; nsel = nx;
        crp_d = dy; crp_oc = ocz; crq_d = dz; crq_oc = ocy;
      end
      2'd1: begin
        dsel = dy; osel = oy; ocsel = ocy; psel = py; bcsel = bcy; nsel = ny;
        crp_d = dz; crp_oc = ocx; crq_d = dx; crq_oc = ocz;
      end
      default: begin
        dsel = dz; osel = oz; ocsel = ocz; psel = pz; bcsel = bcz; nsel = nz;
        crp_d = dx; crp_oc = ocy; crq_d = dy; crq_oc = ocx;
      end
    endcase
    pdiff = psel - bcsel;
  end

  // Operand routing into the shared unit.
  always_comb begin
    alu_req = '0;
    alu_state = 1'b1;
    alu_req.op = rsch_pkg::OP_MUL;
    unique case (st)
      ST_A: begin
        alu_req.a = ext(dsel);
        alu_req.b = ext(dsel);
      end
      ST_CRP: begin
        alu_req.a = ext(crp_d);
        alu_req.b = ext(crp_oc);
      end
      ST_CRQ: begin
        alu_req.a = ext(crq_d);
        alu_req.b = ext(crq_oc);
      end
      ST_CRS: begin
        alu_req.a = ext(m);
        alu_req.b = ext(m);
      end
      ST_R2: begin
        alu_req.a = ext(rr);
        alu_req.b = ext(rr);
      end
      ST_AR2: begin
        alu_req.a = ext(a_reg);
        alu_req.b = ext(r2);
      end
      ST_SQRT: begin
        alu_req.op = rsch_pkg::OP_SQRT;
        alu_req.a = {1'b0, disc};
      end
      ST_H: begin
        alu_req.a = ext(dsel);
        alu_req.b = ext(ocsel);
      end
      ST_ROOT1: begin
        alu_req.op = rsch_pkg::OP_DIV;
        alu_req.a = (ext(h) - {64'd0, s}) << 16;
        alu_req.b = ext(a_reg);
        alu_req.nbits = DIV_T_BITS;
      end
      ST_ROOT2: begin
        alu_req.op = rsch_pkg::OP_DIV;
        alu_req.a = (ext(h) + {64'd0, s}) << 16;
        alu_req.b = ext(a_reg);
        alu_req.nbits = DIV_T_BITS;
      end
      ST_PT: begin
        alu_req.a = ext(best_t);
        alu_req.b = ext(dsel);
      end
      ST_NRM: begin
        alu_req.op = rsch_pkg::OP_DIV;
        alu_req.a = ext(pdiff) << 16;
        alu_req.b = ext(br);
        alu_req.nbits = DIV_N_BITS;
      end
      ST_DOT: begin
        alu_req.a = ext(dsel);
        alu_req.b = ext(nsel);
      end
      default: alu_state = 1'b0;
    endcase
    alu_req.start = alu_state && !issued;
  end

  // Values formed from a finished unit operation.
  always_comb begin
    res_s = alu_rsp.result;
    cr = tmp - $signed(alu_rsp.result[65:0]);
    crmag = cr[65] ? 66'(-cr) : 66'(cr);
    tsat = rsch_pkg::sat32(res_s);
    t_in = (tsat > tmin) && (tsat < closest);
    accept_now = ((st == ST_ROOT1) || (st == ST_ROOT2)) && t_in;
    ptv = rsch_pkg::sat32((res_s >>> 16) + $signed(ext(osel)));
  end

  // Result assembly; a miss leaves every field at zero.
  always_comb begin
    out_next = '0;
    if (best_valid) begin
      out_next.hit = 1'b1;
      out_next.hit_t = best_t;
      out_next.point_x = px;
      out_next.point_y = py;
      out_next.point_z = pz;
      out_next.front_face = dot[65];
      if (dot[65]) begin
        out_next.normal_x = nx;
        out_next.normal_y = ny;
        out_next.normal_z = nz;
      end else begin
        // Negating the most negative value saturates to the maximum.
        out_next.normal_x = (nx == 32'sh80000000) ? 32'sh7fffffff : 32'(-nx);
        out_next.normal_y = (ny == 32'sh80000000) ? 32'sh7fffffff : 32'(-ny);
        out_next.normal_z = (nz == 32'sh80000000) ? 32'sh7fffffff : 32'(-nz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      issued <= 1'b0;
      result_valid <= 1'b0;
      sphere_count <= 7'd0;
      best_valid <= 1'b0;
    end else begin
      if (cfg_we) sphere_count <= cfg_data;
      if (result_valid && result_ready && (st != ST_OUT)) result_valid <= 1'b0;

      if (alu_state) begin
        if (!issued) issued <= 1'b1;
        else if (alu_rsp.done) issued <= 1'b0;
      end

      unique case (st)
        ST_IDLE: begin
          if (query_valid && query.kind) begin
            ox <= query.pos_x;
            oy <= query.pos_y;
            oz <= query.pos_z;
            dx <= query.dir_x;
            dy <= query.dir_y;
            dz <= query.dir_z;
            tmin <= query.t_min;
            closest <= query.t_max;
            a_reg <= '0;
            dot <= '0;
            k <= 2'd0;
            best_valid <= 1'b0;
            st <= ST_A;
          end
        end
        ST_NEXT: begin
          // The walk ends at the count or at once for a zero direction.
          if ((idx >= nlim) || (a_reg == '0)) begin
            k <= 2'd0;
            st <= best_valid ? ST_PT : ST_OUT;
          end else begin
            st <= ST_READ;
          end
        end
        ST_READ: begin
          cx <= rd.cx;
          cy <= rd.cy;
          cz <= rd.cz;
          rr <= rd.r;
          ocx <= rd.cx - ox;
          ocy <= rd.cy - oy;
          ocz <= rd.cz - oz;
          sum <= '0;
          h <= '0;
          k <= 2'd0;
          if (rd.r == '0) begin
            idx <= idx + 1'b1;
            st <= ST_NEXT;
          end else begin
            st <= ST_CRP;
          end
        end
        ST_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid <= 1'b1;
            result <= out_next;
            st <= ST_IDLE;
          end
        end
        default: begin
          if (issued && alu_rsp.done) begin
            unique case (st)
              ST_A: begin
                a_reg <= a_reg + alu_rsp.result[63:0];
                if (k == 2'd2) begin
                  idx <= '0;
                  if (32'(sphere_count) > rsch_pkg::SPHERE_SLOTS)
                    nlim <= rsch_pkg::idx_t'(rsch_pkg::SPHERE_SLOTS);
                  else
                    nlim <= rsch_pkg::idx_t'(sphere_count);
                  st <= ST_NEXT;
                end else begin
                  k <= k + 2'd1;
                end
              end
              ST_CRP: begin
                tmp <= alu_rsp.result[65:0];
                st <= ST_CRQ;
              end
              ST_CRQ: begin
                // A cross component of 2^63 or more in size misses the sphere.
                if (crmag[65:63] != 3'd0) begin
                  idx <= idx + 1'b1;
                  st <= ST_NEXT;
                end else begin
                  m <= crmag[63:0];
                  st <= ST_CRS;
                end
              end
              ST_CRS: begin
                sum <= sum + alu_rsp.result;
                if (k == 2'd2) begin
                  st <= ST_R2;
                end else begin
                  k <= k + 2'd1;
                  st <= ST_CRP;
                end
              end
              ST_R2: begin
                r2 <= alu_rsp.result[61:0];
                st <= ST_AR2;
              end
              ST_AR2: begin
                if (sum > alu_rsp.result) begin
                  idx <= idx + 1'b1;
                  st <= ST_NEXT;
                end else begin
                  disc <= 127'(alu_rsp.result - sum);
                  st <= ST_SQRT;
                end
              end
              ST_SQRT: begin
                s <= alu_rsp.result[63:0];
                k <= 2'd0;
                st <= ST_H;
              end
              ST_H: begin
                h <= h + $signed(alu_rsp.result[66:0]);
                if (k == 2'd2) begin
                  st <= ST_ROOT1;
                end else begin
                  k <= k + 2'd1;
                end
              end
              ST_ROOT1, ST_ROOT2: begin
                if (accept_now) begin
                  closest <= tsat;
                  best_t <= tsat;
                  best_valid <= 1'b1;
                  bcx <= cx;
                  bcy <= cy;
                  bcz <= cz;
                  br <= rr;
                end
                if (accept_now || (st == ST_ROOT2)) begin
                  idx <= idx + 1'b1;
                  st <= ST_NEXT;
                end else begin
                  st <= ST_ROOT2;
                end
              end
              ST_PT: begin
                unique case (k)
                  2'd0: px <= ptv;
                  2'd1: py <= ptv;
                  default: pz <= ptv;
                endcase
                st <= ST_NRM;
              end
              ST_NRM: begin
                unique case (k)
                  2'd0: nx <= tsat;
                  2'd1: ny <= tsat;
                  default: nz <= tsat;
                endcase
                st <= ST_DOT;
              end
              ST_DOT: begin
                dot <= dot + $signed(alu_rsp.result[65:0]);
                if (k == 2'd2) begin
                  st <= ST_OUT;
                end else begin
                  k <= k + 2'd1;
                  st <= ST_PT;
                end
              end
              default: st <= ST_IDLE;
            endcase
          end
        end
      endcase
    end
  end

  // The sequencer never starts the shared unit while it is still working.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    alu_req.start |-> !alu_rsp.busy)
    else $error("shared unit started while busy");

  // The kept hit always lies inside the current interval and bounds it from above.
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    best_valid |-> (best_t == closest) && (best_t > tmin))
    else $error("closest hit outside the interval");

  // A miss reports all fields as zero; hit_t, front_face and normal_x are checked.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.hit) |->
      (result.hit_t == 32'sd0) && !result.front_face && (result.normal_x == 32'sd0))
    else $error("miss result carries data");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the ray-sphere closest-hit block with its own fixed-point predictor.
module tb;

  // Wide signed arithmetic keeps every intermediate exact, as the block does.
  typedef logic signed [255:0] wide_t;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam int UNIT = 65536;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [6:0] cfg_data;
  logic query_valid;
  logic query_ready;
  rsch_pkg::query_t query;
  logic result_valid;
  logic result_ready;
  rsch_pkg::result_t result;

  // Our own copy of the sphere table and of the sphere_count register.
  rsch_pkg::sphere_t sphere_table [rsch_pkg::SPHERE_SLOTS];
  int table_count;

  // Hit records expected from queries that the block has accepted, oldest first.
  rsch_pkg::result_t hit_log [$];

  int fail_count;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;

  ray_sphere_closest_hit_top i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .query_valid(query_valid),
    .query_ready(query_ready),
    .query(query),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic wide_t clamp32(wide_t v);
    if (v > ((wide_t'(1) <<< 31) - 1)) return (wide_t'(1) <<< 31) - 1;
    if (v < -(wide_t'(1) <<< 31)) return -(wide_t'(1) <<< 31);
    return v;
  endfunction

  function automatic wide_t floor_div(wide_t n, wide_t dv);
    wide_t q;
    q = n / dv;
    if ((n % dv) != 0 && n < 0) q = q - 1;
    return q;
  endfunction

  // Floor of num / a for a > 0. A quotient outside 32 bits saturates, and no
  // open interval of 32-bit bounds can then accept it.
  function automatic wide_t root_param(wide_t num, wide_t a);
    wide_t q;
    if (num < 0) begin
      q = (-num + a - 1) / a;
      if (q > (wide_t'(1) <<< 31)) return -(wide_t'(1) <<< 31);
      return -q;
    end
    q = num / a;
    if (q > ((wide_t'(1) <<< 31) - 1)) return (wide_t'(1) <<< 31) - 1;
    return q;
  endfunction

  function automatic wide_t int_sqrt(wide_t n);
    wide_t root;
    wide_t trial;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (wide_t'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Walks the first sphere_count table entries with the half-b quadratic and
  // shades the closest hit strictly inside (t_min, t_max).
  function automatic rsch_pkg::result_t trace_ray(rsch_pkg::query_t q);
    wide_t o [3];
    wide_t d [3];
    wide_t c [3];
    wide_t oc [3];
    wide_t cr [3];
    wide_t p [3];
    wide_t nv [3];
    wide_t a, r, sum, ar2, s, h, t, tmin, closest, best_t, dot;
    logic miss;
    logic front;
    int best;
    int n;
    rsch_pkg::result_t res;
    o[0] = wide_t'(q.pos_x);
    o[1] = wide_t'(q.pos_y);
    o[2] = wide_t'(q.pos_z);
    d[0] = wide_t'(q.dir_x);
    d[1] = wide_t'(q.dir_y);
    d[2] = wide_t'(q.dir_z);
    tmin = wide_t'(q.t_min);
    closest = wide_t'(q.t_max);
    best = -1;
    best_t = 0;
    a = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    n = (table_count > rsch_pkg::SPHERE_SLOTS) ? rsch_pkg::SPHERE_SLOTS : table_count;
    for (int i = 0; i < n && a != 0; i++) begin
      r = wide_t'(sphere_table[i].r);
      if (r == 0) continue;
      c[0] = wide_t'(sphere_table[i].cx);
      c[1] = wide_t'(sphere_table[i].cy);
      c[2] = wide_t'(sphere_table[i].cz);
      for (int k = 0; k < 3; k++) oc[k] = c[k] - o[k];
      cr[0] = d[1] * oc[2] - d[2] * oc[1];
      cr[1] = d[2] * oc[0] - d[0] * oc[2];
      cr[2] = d[0] * oc[1] - d[1] * oc[0];
      sum = 0;
      miss = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (cr[k] >= (wide_t'(1) << 63) || -cr[k] >= (wide_t'(1) << 63)) miss = 1'b1;
        sum = sum + cr[k] * cr[k];
      end
      if (miss) continue;
      // The discriminant is formed from the cross product, which is exact.
      ar2 = a * r * r;
      if (sum > ar2) continue;
      s = int_sqrt(ar2 - sum);
      h = d[0] * oc[0] + d[1] * oc[1] + d[2] * oc[2];
      t = root_param((h - s) <<< 16, a);
      if (!(t > tmin && t < closest)) begin
        t = root_param((h + s) <<< 16, a);
        if (!(t > tmin && t < closest)) continue;
      end
      closest = t;
      best_t = t;
      best = i;
    end
    res = '0;
    if (best >= 0) begin
      c[0] = wide_t'(sphere_table[best].cx);
      c[1] = wide_t'(sphere_table[best].cy);
      c[2] = wide_t'(sphere_table[best].cz);
      r = wide_t'(sphere_table[best].r);
      dot = 0;
      for (int k = 0; k < 3; k++) begin
        p[k] = clamp32(o[k] + ((best_t * d[k]) >>> 16));
        nv[k] = clamp32(floor_div((p[k] - c[k]) <<< 16, r));
        dot = dot + d[k] * nv[k];
      end
      front = (dot < 0);
      for (int k = 0; k < 3; k++) if (!front) nv[k] = clamp32(-nv[k]);
      res.hit = 1'b1;
      res.hit_t = best_t[31:0];
      res.point_x = p[0][31:0];
      res.point_y = p[1][31:0];
      res.point_z = p[2][31:0];
      res.normal_x = nv[0][31:0];
      res.normal_y = nv[1][31:0];
      res.normal_z = nv[2][31:0];
      res.front_face = front;
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  // Each accepted result is matched against the oldest pending hit record.
  always @(posedge clk) begin
    rsch_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (hit_log.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = hit_log.pop_front();
        check_field("hit", 32'(want.hit), 32'(result.hit));
        check_field("hit_t", want.hit_t, result.hit_t);
        check_field("point_x", want.point_x, result.point_x);
        check_field("point_y", want.point_y, result.point_y);
        check_field("point_z", want.point_z, result.point_z);
        check_field("normal_x", want.normal_x, result.normal_x);
        check_field("normal_y", want.normal_y, result.normal_y);
        check_field("normal_z", want.normal_z, result.normal_z);
        check_field("front_face", 32'(want.front_face), 32'(result.front_face));
      end
    end
  end

  // The receiver stalls at random, or for a long counted stretch when the
  // pressure test asks for it.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        result_ready = 1'b0;
        hold_left--;
      end else begin
        result_ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request driving
  // ---------------------------------------------------------------------------

  // Offers one request and waits for the handshake. Loads update our table
  // copy and queries queue their prediction at the accepting edge, so the
  // order of table writes and ray casts matches the block.
  task automatic send_request(rsch_pkg::query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      query_valid = 1'b0;
      @(negedge clk);
    end
    query = q;
    query_valid = 1'b1;
    do @(posedge clk); while (!query_ready);
    if (q.kind == KIND_LOAD) begin
      sphere_table[q.entry_index].cx = q.pos_x;
      sphere_table[q.entry_index].cy = q.pos_y;
      sphere_table[q.entry_index].cz = q.pos_z;
      sphere_table[q.entry_index].r = (q.sphere_radius < 0) ? '0 : q.sphere_radius[30:0];
    end else begin
      hit_log.push_back(trace_ray(q));
    end
    @(negedge clk);
    query_valid = 1'b0;
  endtask

  // Waits until every query has answered; a load has no answer, so a further
  // wait lets a trailing load finish.
  task automatic drain();
    wait (hit_log.size() == 0);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_sphere_count(int value);
    drain();
    cfg_we = 1'b1;
    cfg_data = value[6:0];
    @(negedge clk);
    cfg_we = 1'b0;
    table_count = value;
  endtask

  function automatic rsch_pkg::query_t make_load(int slot, int x, int y, int z, int radius);
    rsch_pkg::query_t q;
    q = '0;
    q.kind = KIND_LOAD;
    q.entry_index = slot[5:0];
    q.pos_x = x;
    q.pos_y = y;
    q.pos_z = z;
    q.sphere_radius = radius;
    return q;
  endfunction

  function automatic rsch_pkg::query_t make_ray(int ox, int oy, int oz, int dx, int dy,
                                                int dz, int tmin, int tmax);
    rsch_pkg::query_t q;
    q = '0;
    q.kind = KIND_QUERY;
    q.entry_index = 6'($urandom);
    q.sphere_radius = 32'($urandom);
    q.pos_x = ox;
    q.pos_y = oy;
    q.pos_z = oz;
    q.dir_x = dx;
    q.dir_y = dy;
    q.dir_z = dz;
    q.t_min = tmin;
    q.t_max = tmax;
    return q;
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // A sphere near the scene centre, sometimes with a zero or negative radius.
  function automatic rsch_pkg::query_t random_sphere(int slot);
    int radius;
    radius = $urandom_range(UNIT, 6 * UNIT);
    if ($urandom_range(15) == 0) radius = -radius;
    if ($urandom_range(15) == 0) radius = 0;
    return make_load(slot, spread(40 * UNIT), spread(40 * UNIT), spread(40 * UNIT), radius);
  endfunction

  // A ray aimed roughly at one of the tested spheres; now and then the
  // origin starts inside it so that the far root and the back face come up.
  function automatic rsch_pkg::query_t aimed_ray();
    int slot, ox, oy, oz, off, tmin, tmax;
    slot = (table_count == 0) ? 0 : $urandom_range(0, (table_count > rsch_pkg::SPHERE_SLOTS) ?
           rsch_pkg::SPHERE_SLOTS - 1 : table_count - 1);
    off = ($urandom_range(9) == 0) ? UNIT : 30 * UNIT;
    ox = sphere_table[slot].cx + spread(off);
    oy = sphere_table[slot].cy + spread(off);
    oz = sphere_table[slot].cz + spread(off);
    tmin = ($urandom_range(1) == 0) ? 0 : spread(UNIT);
    tmax = ($urandom_range(4) == 0) ? $urandom_range(UNIT, 8 * UNIT) : 32'h7fffffff;
    return make_ray(ox, oy, oz,
                    ((sphere_table[slot].cx - ox) >>> 2) + spread(UNIT / 4),
                    ((sphere_table[slot].cy - oy) >>> 2) + spread(UNIT / 4),
                    ((sphere_table[slot].cz - oz) >>> 2) + spread(UNIT / 4),
                    tmin, tmax);
  endfunction

  // Fully random request: every bit of every field is free.
  function automatic rsch_pkg::query_t noise_request();
    rsch_pkg::query_t q;
    q.kind = 1'($urandom);
    q.entry_index = 6'($urandom);
    q.pos_x = 32'($urandom);
    q.pos_y = 32'($urandom);
    q.pos_z = 32'($urandom);
    q.dir_x = 32'($urandom);
    q.dir_y = 32'($urandom);
    q.dir_z = 32'($urandom);
    q.sphere_radius = 32'($urandom);
    q.t_min = 32'($urandom);
    q.t_max = 32'($urandom);
    return q;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every slot is loaded first, so no query ever reads an unwritten entry.
  task automatic test_fill_table();
    for (int i = 0; i < rsch_pkg::SPHERE_SLOTS; i++) send_request(random_sphere(i));
  endtask

  task automatic test_directed();
    // With a count of zero nothing is tested, so even an aimed ray misses.
    set_sphere_count(0);
    send_request(aimed_ray());
    // A count above the table size tests the whole table once.
    set_sphere_count(127);
    send_request(aimed_ray());
    set_sphere_count(64);
    send_request(aimed_ray());
    set_sphere_count(4);
    send_request(make_load(0, 10 * UNIT, 0, 0, -3 * UNIT));
    send_request(make_load(1, 10 * UNIT, 0, 0, 0));
    send_request(make_load(2, 10 * UNIT, 0, 0, 2 * UNIT));
    send_request(make_load(3, 100 * UNIT, 0, 0, UNIT));
    // Head-on hit of the outside surface at t = 8.
    send_request(make_ray(0, 0, 0, UNIT, 0, 0, 0, 32'h7fffffff));
    // From inside the sphere only the far root is in range, on the back face.
    send_request(make_ray(10 * UNIT, 0, 0, UNIT, UNIT / 3, 0, 0, 32'h7fffffff));
    // Zero direction never hits.
    send_request(make_ray(0, 0, 0, 0, 0, 0, -100 * UNIT, 32'h7fffffff));
    // Empty interval.
    send_request(make_ray(0, 0, 0, UNIT, 0, 0, 5 * UNIT, 5 * UNIT));
    // Hit beyond t_max.
    send_request(make_ray(0, 0, 0, UNIT, 0, 0, 0, 7 * UNIT));
    // Grazing ray that misses (negative discriminant).
    send_request(make_ray(0, 3 * UNIT, 0, UNIT, 0, 0, 0, 32'h7fffffff));
    // A tiny direction puts the root far past the 32-bit range.
    send_request(make_ray(0, 0, 0, 1, 0, 0, 32'h80000000, 32'h7fffffff));
    // Negative t range, ray pointing away.
    send_request(make_ray(0, 0, 0, -UNIT, 0, 0, 32'h80000000, 32'h7fffffff));
    // Field extremes.
    send_request(make_ray(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff));
    send_request(make_ray(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    send_request(make_load(63, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    send_request(make_ray(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff));
  endtask

  // Mostly aimed rays with random content, some fresh loads and some noise.
  task automatic test_random_traffic(int sender_idle, int receiver_idle, int items);
    int pick;
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    set_sphere_count($urandom_range(1, 6));
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 20) send_request(random_sphere($urandom_range(0, rsch_pkg::SPHERE_SLOTS - 1)));
      else if (pick < 85) send_request(aimed_ray());
      else send_request(noise_request());
    end
  endtask

  // The receiver holds off while rays keep coming, so the finished result
  // waits and the block must refuse new requests; then the sender stops and drains.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_sphere_count(2);
    hold_left = 6000;
    repeat (5) send_request(aimed_ray());
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    query_valid = 1'b0;
    query = '0;
    fail_count = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 0;
    table_count = 0;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_fill_table();
    test_directed();
    test_random_traffic(34, 62, 20);
    test_random_traffic(62, 34, 20);
    test_random_traffic(0, 0, 20);
    test_backpressure();

    drain();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Hang guard, far above the slowest correct run.
  initial begin
    #400_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
